/* rtl/sorted_slot_table_macros.svh */
// Assertion helpers used by the datapath of the sorted slot table.
`ifndef SORTED_SLOT_TABLE_MACROS_SVH
`define SORTED_SLOT_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SST_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, forces another one on the following edge.
`define SST_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/sst_pkg.sv */
`default_nettype none

package sst_pkg;

   // Size of the key space and of the table.
   localparam int SLOT_RANGE = 64;
   localparam int KEY_LIMIT  = (SLOT_RANGE < 64) ? SLOT_RANGE : 64;
   localparam int IDX_W      = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;
   localparam int CNT_W      = $clog2(KEY_LIMIT + 1);
   localparam logic [CNT_W-1:0] KEY_LIMIT_C = CNT_W'(KEY_LIMIT);

   // Operation codes.
   localparam logic [2:0] OP_SET    = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_MOVE   = 3'd3;
   localparam logic [2:0] OP_FIND   = 3'd4;
   localparam logic [2:0] OP_FREE   = 3'd5;

   typedef struct packed {
      logic [5:0]  key;
      logic [31:0] item;
      logic [31:0] serial;
      logic [15:0] amount;
   } entry_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  slot;
      logic [5:0]  target_slot;
      logic [31:0] item_id;
      logic [31:0] serial;
      logic [15:0] amount;
      logic [15:0] max_stack;
      logic [6:0]  find_limit;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  key_out;
      logic [5:0]  position;
      logic [31:0] item_out;
      logic [31:0] serial_out;
      logic [15:0] amount_out;
      logic [6:0]  match_count;
      logic        last;
   } rsp_type;

   // Pass that the datapath runs over the table.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SCAN,
      MODE_EMIT,
      MODE_UP,
      MODE_DOWN
   } mode_type;

   // Position that a shift pass starts from.
   typedef enum logic [1:0] {
      BASE_POS_S,
      BASE_INS_S,
      BASE_INS_MV
   } base_type;

   // Single entry writes.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_NEW,
      WR_TGT,
      WR_SRC,
      WR_REKEY
   } wr_type;

   // Result beat contents.
   typedef enum logic [2:0] {
      OUT_FAIL,
      OUT_SET,
      OUT_ENTRY,
      OUT_MERGE,
      OUT_REKEY,
      OUT_FREE
   } out_type;

   typedef struct packed {
      logic     load;
      mode_type start;
      base_type base;
      wr_type   wr;
      logic     cnt_inc;
      logic     cnt_dec;
      logic     out_load;
      out_type  out_sel;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic       out_free;
      logic [2:0] op;
      logic       set_ok;
      logic       found_s;
      logic       mv_ok;
      logic       mv_merge;
      logic       ns_zero;
      logic       find_any;
      logic       free_ok;
   } status_type;

endpackage

`default_nettype wire

/* rtl/sst_datapath.sv */
`default_nettype none

`include "sorted_slot_table_macros.svh"

module sst_datapath import sst_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp,
   output logic       rsp_valid,
   input  wire        rsp_ready
);

   // Entry store, one read and one write port, registered read data.
   entry_type mem [KEY_LIMIT];

   req_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   entry_type        rd_data_ff;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] base_ff, base_in;
   mode_type         mode_ff, mode_in;

   // Scan results.
   logic             found_s_ff, found_t_ff;
   logic [IDX_W-1:0] pos_s_ff, pos_t_ff;
   entry_type        rec_s_ff, rec_t_ff;
   logic [CNT_W-1:0] ins_s_ff, ins_t_ff, want_ff;
   logic             run_ff;
   logic [6:0]       n_total_ff, n_emit_ff;

   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             match, emit_stall, emit_take, out_free, out_load;
   logic [6:0]       lim;
   logic [CNT_W-1:0] ins_mv, merge_pos;
   logic [16:0]      total, nt, ns_full;
   logic [15:0]      ns;
   logic [5:0]       fail_key;
   rsp_type          rsp_in;

   // Find limit taken into the range one to sixty-four.
   always_comb begin
      if (req_ff.find_limit == 7'd0) begin
         lim = 7'd1;
      end else if (req_ff.find_limit > 7'd64) begin
         lim = 7'd64;
      end else begin
         lim = req_ff.find_limit;
      end
   end

   // Stack merge arithmetic.
   assign total   = {1'b0, rec_s_ff.amount} + {1'b0, rec_t_ff.amount};
   assign nt      = (total < {1'b0, req_ff.max_stack}) ? total : {1'b0, req_ff.max_stack};
   assign ns_full = total - nt;
   assign ns      = ns_full[16] ? 16'hFFFF : ns_full[15:0];

   // Insert place of the target once the source has been taken out.
   assign ins_mv    = ins_t_ff - CNT_W'(req_ff.slot < req_ff.target_slot);
   assign merge_pos = CNT_W'(pos_t_ff)
                    - CNT_W'((ns == 16'd0) && (pos_s_ff < pos_t_ff));

   assign match      = (rd_data_ff.item == req_ff.item_id);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_stall = rd_vld_ff && match && !out_free;
   assign emit_take  = (mode_ff == MODE_EMIT) && rd_vld_ff && match && out_free
                     && (n_emit_ff < n_total_ff);

   // Status to the controller.
   always_comb begin
      status.busy     = (mode_ff != MODE_IDLE);
      status.out_free = out_free;
      status.op       = req_ff.op;
      status.set_ok   = !found_s_ff && (CNT_W'(req_ff.slot) < KEY_LIMIT_C)
                      && (count_ff < KEY_LIMIT_C);
      status.found_s  = found_s_ff;
      status.mv_ok    = (req_ff.slot != req_ff.target_slot) && found_s_ff
                      && (found_t_ff ? ((rec_s_ff.serial == rec_t_ff.serial)
                                        && (req_ff.max_stack > 16'd1))
                                     : (CNT_W'(req_ff.target_slot) < KEY_LIMIT_C));
      status.mv_merge = found_t_ff;
      status.ns_zero  = (ns == 16'd0);
      status.find_any = (n_total_ff != 7'd0);
      status.free_ok  = (want_ff < KEY_LIMIT_C);
   end

   // Pass sequencing: pointer, reads and end of pass.
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = '0;
      rd_vld_in = 1'b0;
      ptr_in    = ptr_ff;
      mode_in   = mode_ff;
      base_in   = base_ff;
      case (mode_ff)
         MODE_SCAN: begin
            if (ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = ptr_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_EMIT: begin
            if ((n_emit_ff == n_total_ff) || ((n_emit_ff + 7'd1 == n_total_ff) && emit_take)) begin
               mode_in = MODE_IDLE;
            end else if (emit_stall) begin
               rd_vld_in = 1'b1;
            end else if (ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = ptr_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end
         MODE_UP: begin
            if (ptr_ff > base_ff) begin
               rd_en     = 1'b1;
               rd_addr   = IDX_W'(ptr_ff - 1'b1);
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff - 1'b1;
            end else if (!rd_vld_ff) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_DOWN: begin
            if (ptr_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = ptr_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // The controller must start a new pass only from idle; the datapath itself does not enforce it.
      if (cmd.start != MODE_IDLE) begin
         mode_in = cmd.start;
         case (cmd.base)
            BASE_INS_S:  base_in = ins_s_ff;
            BASE_INS_MV: base_in = ins_mv;
            default:     base_in = CNT_W'(pos_s_ff);
         endcase
         case (cmd.start)
            MODE_UP:   ptr_in = count_in;
            MODE_DOWN: ptr_in = base_in + 1'b1;
            default:   ptr_in = '0;
         endcase
      end
   end

   // Count of entries held.
   assign count_in = count_ff + CNT_W'(cmd.cnt_inc) - CNT_W'(cmd.cnt_dec);

   // Write port: shift copies, else single entry writes.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data_ff;
      if ((mode_ff == MODE_UP) && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff + 1'b1;
      end else if ((mode_ff == MODE_DOWN) && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - 1'b1;
      end else begin
         case (cmd.wr)
            WR_NEW: begin
               wr_en   = 1'b1;
               wr_addr = ins_s_ff[IDX_W-1:0];
               wr_data = '{key: req_ff.slot, item: req_ff.item_id,
                           serial: req_ff.serial, amount: req_ff.amount};
            end
            WR_TGT: begin
               wr_en          = 1'b1;
               wr_addr        = pos_t_ff;
               wr_data        = rec_t_ff;
               wr_data.amount = nt[15:0];
            end
            WR_SRC: begin
               wr_en          = 1'b1;
               wr_addr        = pos_s_ff;
               wr_data        = rec_s_ff;
               wr_data.amount = ns;
            end
            WR_REKEY: begin
               wr_en       = 1'b1;
               wr_addr     = ins_mv[IDX_W-1:0];
               wr_data     = rec_s_ff;
               wr_data.key = req_ff.target_slot;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // Memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Fail key follows the operation.
   always_comb begin
      case (req_ff.op)
         OP_SET, OP_CLEAR, OP_LOOKUP: fail_key = req_ff.slot;
         OP_MOVE:                     fail_key = req_ff.target_slot;
         default:                     fail_key = 6'd0;
      endcase
   end

   // Result beat selection.
   assign out_load = emit_take || (cmd.out_load && out_free);
   always_comb begin
      rsp_in      = '0;
      rsp_in.last = 1'b1;
      if (emit_take) begin
         rsp_in.ok          = 1'b1;
         rsp_in.key_out     = rd_data_ff.key;
         rsp_in.position    = 6'(rd_idx_ff);
         rsp_in.item_out    = rd_data_ff.item;
         rsp_in.serial_out  = rd_data_ff.serial;
         rsp_in.amount_out  = rd_data_ff.amount;
         rsp_in.match_count = n_emit_ff + 7'd1;
         rsp_in.last        = (n_emit_ff + 7'd1 == n_total_ff);
      end else begin
         case (cmd.out_sel)
            OUT_SET: begin
               rsp_in.ok         = 1'b1;
               rsp_in.key_out    = req_ff.slot;
               rsp_in.position   = 6'(ins_s_ff);
               rsp_in.item_out   = req_ff.item_id;
               rsp_in.serial_out = req_ff.serial;
               rsp_in.amount_out = req_ff.amount;
            end
            OUT_ENTRY: begin
               rsp_in.ok         = 1'b1;
               rsp_in.key_out    = req_ff.slot;
               rsp_in.position   = 6'(pos_s_ff);
               rsp_in.item_out   = rec_s_ff.item;
               rsp_in.serial_out = rec_s_ff.serial;
               rsp_in.amount_out = rec_s_ff.amount;
            end
            OUT_MERGE: begin
               rsp_in.ok         = 1'b1;
               rsp_in.key_out    = req_ff.target_slot;
               rsp_in.position   = 6'(merge_pos);
               rsp_in.item_out   = rec_t_ff.item;
               rsp_in.serial_out = rec_t_ff.serial;
               rsp_in.amount_out = nt[15:0];
            end
            OUT_REKEY: begin
               rsp_in.ok         = 1'b1;
               rsp_in.key_out    = req_ff.target_slot;
               rsp_in.position   = 6'(ins_mv);
               rsp_in.item_out   = rec_s_ff.item;
               rsp_in.serial_out = rec_s_ff.serial;
               rsp_in.amount_out = rec_s_ff.amount;
            end
            OUT_FREE: begin
               rsp_in.ok       = 1'b1;
               rsp_in.key_out  = 6'(want_ff);
               rsp_in.position = 6'(want_ff);
            end
            default: begin
               rsp_in.key_out = fail_key;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mode_ff      <= MODE_IDLE;
         rd_vld_ff    <= 1'b0;
         ptr_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         rd_vld_ff <= rd_vld_in;
         ptr_ff    <= ptr_in;
         base_ff   <= base_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, scan accumulators and result register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
      if (cmd.start == MODE_SCAN) begin
         found_s_ff <= 1'b0;
         found_t_ff <= 1'b0;
         ins_s_ff   <= '0;
         ins_t_ff   <= '0;
         want_ff    <= '0;
         run_ff     <= 1'b1;
         n_total_ff <= '0;
      end else if ((mode_ff == MODE_SCAN) && rd_vld_ff) begin
         if (rd_data_ff.key == req_ff.slot) begin
            found_s_ff <= 1'b1;
            pos_s_ff   <= rd_idx_ff;
            rec_s_ff   <= rd_data_ff;
         end
         if (rd_data_ff.key == req_ff.target_slot) begin
            found_t_ff <= 1'b1;
            pos_t_ff   <= rd_idx_ff;
            rec_t_ff   <= rd_data_ff;
         end
         if (rd_data_ff.key < req_ff.slot) begin
            ins_s_ff <= ins_s_ff + 1'b1;
         end
         if (rd_data_ff.key < req_ff.target_slot) begin
            ins_t_ff <= ins_t_ff + 1'b1;
         end
         if (run_ff && (CNT_W'(rd_data_ff.key) == want_ff)) begin
            want_ff <= want_ff + 1'b1;
         end else begin
            run_ff <= 1'b0;
         end
         if (match && (n_total_ff < lim)) begin
            n_total_ff <= n_total_ff + 7'd1;
         end
      end
      if (cmd.start == MODE_EMIT) begin
         n_emit_ff <= '0;
      end else if (emit_take) begin
         n_emit_ff <= n_emit_ff + 7'd1;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // The table never holds more entries than there are keys.
   `SST_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= KEY_LIMIT_C, "entry count above table size")
   // A find pass never reports more matches than it counted.
   `SST_ASSERT_ALWAYS(a_emit_bound, clock, reset, (mode_ff != MODE_EMIT) || (n_emit_ff <= n_total_ff), "find reported too many matches")
   // A match that waits for the result register keeps its read data.
   `SST_ASSERT_NEXT(a_stall_hold, clock, reset, (mode_ff == MODE_EMIT) && emit_stall && (n_emit_ff != n_total_ff), $stable(rd_data_ff) && rd_vld_ff, "stalled match lost its data")

endmodule

`default_nettype wire

/* rtl/sst_controller.sv */
`default_nettype none

module sst_controller import sst_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_EMIT,
      S_UP,
      S_DOWN,
      S_WR_NEW,
      S_WR_TGT,
      S_WR_SRC,
      S_WR_REKEY,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   out_type   out_sel_ff, out_sel_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      out_sel_in  = out_sel_ff;
      cmd         = '0;
      cmd.start   = MODE_IDLE;
      cmd.base    = BASE_POS_S;
      cmd.wr      = WR_NONE;
      cmd.out_sel = out_sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.start = MODE_SCAN;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!status.busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            out_sel_in = OUT_FAIL;
            state_in   = S_RESP;
            case (status.op)
               OP_SET: begin
                  if (status.set_ok) begin
                     cmd.start  = MODE_UP;
                     cmd.base   = BASE_INS_S;
                     out_sel_in = OUT_SET;
                     state_in   = S_UP;
                  end
               end
               OP_CLEAR: begin
                  if (status.found_s) begin
                     cmd.start  = MODE_DOWN;
                     out_sel_in = OUT_ENTRY;
                     state_in   = S_DOWN;
                  end
               end
               OP_LOOKUP: begin
                  if (status.found_s) begin
                     out_sel_in = OUT_ENTRY;
                  end
               end
               OP_MOVE: begin
                  if (status.mv_ok && status.mv_merge) begin
                     out_sel_in = OUT_MERGE;
                     state_in   = S_WR_TGT;
                  end else if (status.mv_ok) begin
                     cmd.start  = MODE_DOWN;
                     out_sel_in = OUT_REKEY;
                     state_in   = S_DOWN;
                  end
               end
               OP_FIND: begin
                  if (status.find_any) begin
                     cmd.start = MODE_EMIT;
                     state_in  = S_EMIT;
                  end
               end
               OP_FREE: begin
                  if (status.free_ok) begin
                     out_sel_in = OUT_FREE;
                  end
               end
               default: begin
                  out_sel_in = OUT_FAIL;
               end
            endcase
         end
         S_EMIT: begin
            if (!status.busy) begin
               state_in = S_IDLE;
            end
         end
         S_DOWN: begin
            if (!status.busy) begin
               cmd.cnt_dec = 1'b1;
               if ((status.op == OP_MOVE) && !status.mv_merge) begin
                  cmd.start = MODE_UP;
                  cmd.base  = BASE_INS_MV;
                  state_in  = S_UP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_UP: begin
            if (!status.busy) begin
               state_in = (status.op == OP_SET) ? S_WR_NEW : S_WR_REKEY;
            end
         end
         S_WR_NEW: begin
            cmd.wr      = WR_NEW;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_WR_REKEY: begin
            cmd.wr      = WR_REKEY;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESP;
         end
         S_WR_TGT: begin
            cmd.wr   = WR_TGT;
            state_in = S_WR_SRC;
         end
         S_WR_SRC: begin
            cmd.wr = WR_SRC;
            if (status.ns_zero) begin
               cmd.start = MODE_DOWN;
               state_in  = S_DOWN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.out_load = 1'b1;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered result selection.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_sel_ff <= OUT_FAIL;
      end else begin
         state_ff   <= state_in;
         out_sel_ff <= out_sel_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sorted_slot_table.sv */
`default_nettype none

// Sorted slot table: up to 64 entries (key, item, serial, amount) kept in
// ascending key order in a single-port-read memory. One request beat carries
// one operation (set, clear, lookup, move, find by item, first free key) and
// gives one result beat, or for find up to find_limit beats (a limit of zero
// counts as one, above 64 as 64) with tlast on the final one. Every
// operation first scans the table, one entry per cycle; set, clear and a
// move that empties its source then shift the entries above the affected
// place by one, again one entry per cycle through the memory port, and find
// reads the table a second time while it reports. A move into an empty slot
// shifts the table down and then up again. A new request is taken once the
// previous one has placed its last result in the output register.
module sorted_slot_table import sst_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   // slot[5:0], target_slot[11:6], item_id[43:12], serial[75:44],
   // amount[91:76], max_stack[107:92], find_limit[114:108], zero pad
   input  wire [119:0]  req_tdata,
   // op[2:0]
   input  wire [2:0]    req_tuser,
   input  wire          req_tvalid,
   output logic         req_tready,
   // ok[0], key_out[6:1], position[12:7], item_out[44:13],
   // serial_out[76:45], amount_out[92:77], match_count[99:93], zero pad
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready
);

   req_type    req;
   rsp_type    rsp;
   cmd_type    cmd;
   status_type status;

   // Request beat fields.
   always_comb begin
      req.op          = req_tuser;
      req.slot        = req_tdata[5:0];
      req.target_slot = req_tdata[11:6];
      req.item_id     = req_tdata[43:12];
      req.serial      = req_tdata[75:44];
      req.amount      = req_tdata[91:76];
      req.max_stack   = req_tdata[107:92];
      req.find_limit  = req_tdata[114:108];
   end

   sst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sst_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   // Result beat fields.
   assign rsp_tdata = {4'd0, rsp.match_count, rsp.amount_out, rsp.serial_out,
                       rsp.item_out, rsp.position, rsp.key_out, rsp.ok};
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

/* tb/tb_sorted_slot_table.sv */
`default_nettype none

module tb_sorted_slot_table;
   import sst_pkg::*;

   localparam int TBL = 64;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [119:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   wire  [103:0] rsp_tdata;
   wire          rsp_tlast;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;

   sorted_slot_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #6 clock = ~clock;

   // Shadow copy of the table, in sorted order.
   logic [5:0]  tab_key    [TBL];
   logic [31:0] tab_item   [TBL];
   logic [31:0] tab_serial [TBL];
   logic [15:0] tab_amount [TBL];
   int          tab_count;

   rsp_type     pending_rsp [$];
   int          errors;
   bit          idling;

   // Directed rows: the request, and a typed expectation where one is given.
   req_type     row_req   [$];
   bit          row_typed [$];
   rsp_type     row_rsp   [$];

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int find_key(logic [5:0] key);
      for (int i = 0; i < tab_count; i++) begin
         if (tab_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int sorted_place(logic [5:0] key);
      for (int i = 0; i < tab_count; i++) begin
         if (tab_key[i] > key) return i;
      end
      return tab_count;
   endfunction

   function automatic void drop_entry(int p);
      for (int i = p; i + 1 < tab_count; i++) begin
         tab_key[i]    = tab_key[i+1];
         tab_item[i]   = tab_item[i+1];
         tab_serial[i] = tab_serial[i+1];
         tab_amount[i] = tab_amount[i+1];
      end
      tab_count--;
   endfunction

   function automatic void add_entry(int p, logic [5:0] key, logic [31:0] item,
                                     logic [31:0] ser, logic [15:0] amt);
      for (int i = tab_count; i > p; i--) begin
         tab_key[i]    = tab_key[i-1];
         tab_item[i]   = tab_item[i-1];
         tab_serial[i] = tab_serial[i-1];
         tab_amount[i] = tab_amount[i-1];
      end
      tab_key[p]    = key;
      tab_item[p]   = item;
      tab_serial[p] = ser;
      tab_amount[p] = amt;
      tab_count++;
   endfunction

   function automatic rsp_type fail_beat(logic [5:0] key);
      rsp_type r;
      r         = '0;
      r.key_out = key;
      r.last    = 1'b1;
      return r;
   endfunction

   function automatic rsp_type entry_beat(logic [5:0] key, int p);
      rsp_type r;
      r            = '0;
      r.ok         = 1'b1;
      r.key_out    = key;
      r.position   = 6'(p);
      r.item_out   = tab_item[p];
      r.serial_out = tab_serial[p];
      r.amount_out = tab_amount[p];
      r.last       = 1'b1;
      return r;
   endfunction

   // Applies one operation to the shadow table and returns its result beats.
   function automatic void apply_table_op(req_type q, ref rsp_type beats[$]);
      int      p, t, lim, n, want;
      int      total, nt, ns;
      rsp_type r;
      logic [31:0] it, sr;
      logic [15:0] am;
      beats.delete();
      case (q.op)
         OP_SET: begin
            if (find_key(q.slot) >= 0 || tab_count >= TBL) begin
               beats.push_back(fail_beat(q.slot));
            end else begin
               p = sorted_place(q.slot);
               add_entry(p, q.slot, q.item_id, q.serial, q.amount);
               beats.push_back(entry_beat(q.slot, p));
            end
         end
         OP_CLEAR, OP_LOOKUP: begin
            p = find_key(q.slot);
            if (p < 0) begin
               beats.push_back(fail_beat(q.slot));
            end else begin
               beats.push_back(entry_beat(q.slot, p));
               if (q.op == OP_CLEAR) drop_entry(p);
            end
         end
         OP_MOVE: begin
            p = find_key(q.slot);
            t = find_key(q.target_slot);
            if (q.slot == q.target_slot || p < 0) begin
               beats.push_back(fail_beat(q.target_slot));
            end else if (t >= 0) begin
               // Merge stacks of the same serial; an empty source goes away.
               if (tab_serial[p] != tab_serial[t] || q.max_stack <= 1) begin
                  beats.push_back(fail_beat(q.target_slot));
               end else begin
                  total = tab_amount[p] + tab_amount[t];
                  nt    = (total < q.max_stack) ? total : q.max_stack;
                  ns    = total - nt;
                  if (ns > 65535) ns = 65535;
                  tab_amount[t] = 16'(nt);
                  tab_amount[p] = 16'(ns);
                  if (ns == 0) begin
                     drop_entry(p);
                     if (p < t) t--;
                  end
                  beats.push_back(entry_beat(q.target_slot, t));
               end
            end else begin
               // Rekey into an empty slot.
               it = tab_item[p];
               sr = tab_serial[p];
               am = tab_amount[p];
               drop_entry(p);
               t = sorted_place(q.target_slot);
               add_entry(t, q.target_slot, it, sr, am);
               beats.push_back(entry_beat(q.target_slot, t));
            end
         end
         OP_FIND: begin
            lim = q.find_limit;
            if (lim == 0) lim = 1;
            if (lim > 64) lim = 64;
            n = 0;
            for (int i = 0; i < tab_count && n < lim; i++) begin
               if (tab_item[i] == q.item_id) begin
                  r             = entry_beat(tab_key[i], i);
                  r.match_count = 7'(n + 1);
                  r.last        = 1'b0;
                  beats.push_back(r);
                  n++;
               end
            end
            if (n == 0) beats.push_back(fail_beat(6'd0));
            else beats[n-1].last = 1'b1;
         end
         OP_FREE: begin
            want = 0;
            for (int i = 0; i < tab_count; i++) begin
               if (tab_key[i] == want) want++;
               else break;
            end
            if (want >= TBL) begin
               beats.push_back(fail_beat(6'd0));
            end else begin
               r          = fail_beat(6'(want));
               r.ok       = 1'b1;
               r.position = 6'(want);
               beats.push_back(r);
            end
         end
         default: beats.push_back(fail_beat(6'd0));
      endcase
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [5:0] slot, logic [5:0] tgt,
                                        logic [31:0] item, logic [31:0] ser,
                                        logic [15:0] amt, logic [15:0] maxs,
                                        logic [6:0] lim);
      req_type q;
      q.op          = op;
      q.slot        = slot;
      q.target_slot = tgt;
      q.item_id     = item;
      q.serial      = ser;
      q.amount      = amt;
      q.max_stack   = maxs;
      q.find_limit  = lim;
      return q;
   endfunction

   function automatic void add_row(req_type q, bit typed, logic ok, logic [5:0] key,
                                   logic [5:0] pos);
      rsp_type r;
      r          = fail_beat(key);
      r.ok       = ok;
      r.position = pos;
      row_req.push_back(q);
      row_typed.push_back(typed);
      row_rsp.push_back(r);
   endfunction

   // Random request over keys 0..key_hi, with small pools so that merges and
   // finds actually meet.
   function automatic req_type random_req(int key_hi);
      req_type     q;
      int          pick;
      logic [31:0] items [4] = '{32'hA5A5_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
      q      = '0;
      pick   = $urandom_range(0, 99);
      q.op   = (pick < 30) ? OP_SET : (pick < 44) ? OP_CLEAR : (pick < 54) ? OP_LOOKUP :
               (pick < 76) ? OP_MOVE : (pick < 88) ? OP_FIND : (pick < 96) ? OP_FREE :
               3'($urandom_range(6, 7));
      q.slot        = 6'($urandom_range(0, key_hi));
      q.target_slot = 6'($urandom_range(0, key_hi));
      q.item_id     = ($urandom_range(0, 3) == 0) ? $urandom : items[$urandom_range(0, 3)];
      q.serial      = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(1, 3));
      q.amount      = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      pick          = $urandom_range(0, 5);
      q.max_stack   = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF :
                      16'($urandom);
      q.find_limit  = 7'($urandom);
      return q;
   endfunction

   // Drives one request beat and predicts its results once it is taken.
   task automatic send_req(req_type q, bit typed, rsp_type typed_rsp);
      rsp_type beats [$];
      if (idling && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tdata  = {5'd0, q.find_limit, q.max_stack, q.amount, q.serial, q.item_id,
                    q.target_slot, q.slot};
      req_tuser  = q.op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_table_op(q, beats);
      if (typed) begin
         if (beats.size() != 1 || beats[0] != typed_rsp)
            $display("NOTE: typed expectation differs from prediction at %0t", $time);
         pending_rsp.push_back(typed_rsp);
      end else begin
         foreach (beats[i]) pending_rsp.push_back(beats[i]);
      end
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Result side: random stall bursts while idling is on.
   always @(negedge clock) begin
      if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 14) - 1) @(negedge clock);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Compares each result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected beat", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[0] != want.ok) report("ok", rsp_tdata[0], want.ok);
            if (rsp_tdata[6:1] != want.key_out) report("key_out", rsp_tdata[6:1], want.key_out);
            if (rsp_tdata[12:7] != want.position)
               report("position", rsp_tdata[12:7], want.position);
            if (rsp_tdata[44:13] != want.item_out)
               report("item_out", rsp_tdata[44:13], want.item_out);
            if (rsp_tdata[76:45] != want.serial_out)
               report("serial_out", rsp_tdata[76:45], want.serial_out);
            if (rsp_tdata[92:77] != want.amount_out)
               report("amount_out", rsp_tdata[92:77], want.amount_out);
            if (rsp_tdata[99:93] != want.match_count)
               report("match_count", rsp_tdata[99:93], want.match_count);
            if (rsp_tdata[103:100] != 4'd0) report("pad", rsp_tdata[103:100], 32'd0);
            if (rsp_tlast != want.last) report("last", rsp_tlast, want.last);
         end
      end
   end

   // Hard limit on the run.
   initial begin
      #60000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int      order [TBL];
      int      j, tmp;
      rsp_type none;
      none      = '0;
      errors    = 0;
      tab_count = 0;
      idling    = 1'b1;

      // Directed rows: empty table cases, extremes, merges, rekey and finds.
      add_row(make_req(OP_FREE, 0, 0, 0, 0, 0, 0, 1), 1, 1, 0, 0);
      add_row(make_req(OP_LOOKUP, 5, 0, 0, 0, 0, 0, 1), 1, 0, 5, 0);
      add_row(make_req(OP_CLEAR, 63, 0, 0, 0, 0, 0, 1), 1, 0, 63, 0);
      add_row(make_req(OP_FIND, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
      add_row(make_req(OP_MOVE, 3, 3, 0, 0, 0, 9, 1), 1, 0, 3, 0);
      add_row(make_req(OP_MOVE, 7, 9, 0, 0, 0, 9, 1), 1, 0, 9, 0);
      add_row(make_req(3'd6, 63, 63, '1, '1, '1, '1, '1), 1, 0, 0, 0);
      add_row(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
      add_row(make_req(OP_SET, 0, 63, '1, '1, '1, '1, '1), 0, 0, 0, 0);
      add_row(make_req(OP_SET, 63, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
      add_row(make_req(OP_SET, 0, 0, 7, 7, 7, 0, 1), 1, 0, 0, 0);
      add_row(make_req(OP_SET, 10, 0, 32'hA, 5, 30, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_SET, 20, 0, 32'hA, 5, 50, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_MOVE, 10, 20, 0, 0, 0, 1, 1), 1, 0, 20, 0);
      add_row(make_req(OP_MOVE, 10, 20, 0, 0, 0, 0, 1), 1, 0, 20, 0);
      add_row(make_req(OP_MOVE, 10, 20, 0, 0, 0, 60, 1), 0, 0, 0, 0);
      add_row(make_req(OP_MOVE, 10, 20, 0, 0, 0, 100, 1), 0, 0, 0, 0);
      add_row(make_req(OP_MOVE, 20, 30, 0, 0, 0, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_SET, 40, 0, 32'hA, 6, 5, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_MOVE, 40, 30, 0, 0, 0, 100, 1), 1, 0, 30, 0);
      add_row(make_req(OP_SET, 50, 0, 32'hB, 9, '1, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_SET, 51, 0, 32'hB, 9, '1, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_MOVE, 50, 51, 0, 0, 0, 2, 1), 0, 0, 0, 0);
      add_row(make_req(OP_FREE, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_FIND, 0, 0, 32'hA, 0, 0, 0, 7'h7F), 0, 0, 0, 0);
      add_row(make_req(OP_FIND, 0, 0, 32'hA, 0, 0, 0, 1), 0, 0, 0, 0);
      add_row(make_req(OP_CLEAR, 63, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (row_req[i]) send_req(row_req[i], row_typed[i], row_rsp[i]);

      // Hold the sender off until the table has answered everything.
      stop_sending();
      wait (pending_rsp.size() == 0);

      // Fill every key in shuffled order, then probe the full table.
      for (int i = 0; i < TBL; i++) order[i] = i;
      for (int i = TBL - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < TBL; i++)
         send_req(make_req(OP_SET, 6'(order[i]), 0, 32'hA5A5_0001, 32'($urandom_range(1, 3)),
                           16'($urandom), 0, 1), 0, none);
      send_req(make_req(OP_FREE, 0, 0, 0, 0, 0, 0, 1), 1, fail_beat(6'd0));
      send_req(make_req(OP_FIND, 0, 0, 32'hA5A5_0001, 0, 0, 0, 7'd64), 0, none);
      send_req(make_req(OP_SET, 6'($urandom), 0, 1, 1, 1, 0, 1), 0, none);

      // Random mix; the last stretch runs without idling.
      for (int i = 0; i < 12; i++) begin
         if (i == 9) idling = 1'b0;
         send_req(random_req((i < 4) ? 63 : 15), 0, none);
      end
      stop_sending();

      wait (pending_rsp.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_datapath.sv
rtl/sst_controller.sv
rtl/sorted_slot_table.sv
tb/tb_sorted_slot_table.sv
